@@ rtl/line_gap_linear_fill_top_macros.svh @@
// Assertion macros for the checker file of the line gap fill block.
`ifndef LINE_GAP_LINEAR_FILL_TOP_MACROS_SVH
`define LINE_GAP_LINEAR_FILL_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define LGLF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define LGLF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks across reset.
`define LGLF_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lglf_pkg.sv @@
// Package: shared constants, command type and back-end states of the gap fill block.
`default_nettype none
package lglf_pkg;

   localparam int CELL_W         = 13;  // signed cell field
   localparam int VAL_W          = 12;  // coordinate magnitude
   localparam int GAP_W          = 6;   // held-back gap counter
   localparam int CNT_W          = 7;   // results per command, up to MAX_GAP + 1
   localparam int RW             = 8;   // rounding accumulator, below 4 * gap
   localparam int DIV_STEP_W     = 4;   // divider step counter
   localparam int MAX_GAP        = 63;
   localparam int COORD_BITS_DEF = 12;

   localparam logic [CELL_W-1:0] MISSING = {CELL_W{1'b1}};

   typedef enum logic {
      CMD_FILL,   // gap cells (filled or missing), then the known value
      CMD_MISS    // a run of missing cells only
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [CNT_W-1:0] count;
      logic             anc_ok;
      logic [VAL_W-1:0] anchor;
      logic [VAL_W-1:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_GAP,
      BK_LAST
   } back_state_type;

endpackage
`default_nettype wire

@@ rtl/lglf_if.sv @@
// Interfaces: request and response channels with valid/ready handshake.
`default_nettype none
interface lglf_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [lglf_pkg::CELL_W-1:0] cell_value;
   logic                              end_of_line;

   modport source (output valid, output cell_value, output end_of_line, input ready);
   modport sink   (input valid, input cell_value, input end_of_line, output ready);
endinterface

interface lglf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [lglf_pkg::CELL_W-1:0] filled_value;
   logic                              last_of_run;

   modport source (output valid, output filled_value, output last_of_run, input ready);
   modport sink   (input valid, input filled_value, input last_of_run, output ready);
endinterface
`default_nettype wire

@@ rtl/line_gap_linear_fill_top.sv @@
// Top level of the line gap linear fill block: front end, command queue, back end.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+-------------------------------------------
//   req_chan  | in  | valid / ready | cell_value (13 s), end_of_line (1)
//   rsp_chan  | out | valid / ready | filled_value (13 s), last_of_run (1)
//
// A cell is accepted whenever the two-entry command queue has room.
// The back end takes a command, then drives its results: a known cell with no gap gives
// its value; a filled gap of k cells first runs the divider (one quotient bit per cycle),
// then adds k; a gap with no anchor adds k missing cells; a missing run gives k only.
// Reset is synchronous and clears the line state, the queue and the output valid flag.
// A stalled rsp_chan holds its result; the queue lets the front keep accepting cells until it is full.
`default_nettype none
module line_gap_linear_fill_top #(
   parameter int COORD_BITS = lglf_pkg::COORD_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lglf_req_if.sink   req_chan,
   lglf_rsp_if.source rsp_chan
);

   logic               q_full;
   logic               q_push;
   lglf_pkg::cmd_type  q_push_cmd;
   logic               q_pop;
   lglf_pkg::cmd_type  q_pop_cmd;
   logic               q_avail;

   // classify cells and hold the gap until its right-hand value arrives
   lglf_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (q_push),
      .push_cmd (q_push_cmd)
   );

   // decouple acceptance from result bursts
   lglf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (q_pop_cmd),
      .avail    (q_avail)
   );

   // expand each command into its run of results
   lglf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_avail  (q_avail),
      .q_cmd    (q_pop_cmd),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

@@ rtl/lglf_front.sv @@
// Front end: accept cells, track anchor and gap, issue commands to the queue.
`default_nettype none
module lglf_front #(
   parameter int COORD_BITS = lglf_pkg::COORD_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   lglf_req_if.sink               req_chan,
   input  wire logic              q_full,
   output logic                   push,
   output lglf_pkg::cmd_type      push_cmd
);

   localparam int AW = (COORD_BITS < lglf_pkg::VAL_W) ? COORD_BITS : lglf_pkg::VAL_W;
   localparam logic [lglf_pkg::VAL_W-1:0] CMAX = lglf_pkg::VAL_W'((1 << AW) - 1);

   logic [AW-1:0]                 anchor_ff, anchor_in;
   logic                          anc_ok_ff, anc_ok_in;
   logic [lglf_pkg::GAP_W-1:0]    gap_ff, gap_in;
   logic                          ovf_ff, ovf_in;

   logic                          accept;
   logic                          missing;
   logic [lglf_pkg::VAL_W-1:0]    raw;
   logic [AW-1:0]                 sat;
   logic [lglf_pkg::CNT_W-1:0]    gap_plus;

   assign req_chan.ready = !q_full;
   assign accept   = req_chan.valid && !q_full;
   assign missing  = req_chan.cell_value[lglf_pkg::CELL_W-1];
   assign raw      = req_chan.cell_value[lglf_pkg::VAL_W-1:0];
   assign sat      = (raw > CMAX) ? CMAX[AW-1:0] : raw[AW-1:0];
   assign gap_plus = lglf_pkg::CNT_W'(gap_ff) + lglf_pkg::CNT_W'(1);

   always_comb begin
      anchor_in       = anchor_ff;
      anc_ok_in       = anc_ok_ff;
      gap_in          = gap_ff;
      ovf_in          = ovf_ff;
      push            = 1'b0;
      push_cmd.kind   = lglf_pkg::CMD_MISS;
      push_cmd.count  = gap_plus;
      push_cmd.anc_ok = anc_ok_ff;
      push_cmd.anchor = lglf_pkg::VAL_W'(anchor_ff);
      push_cmd.value  = lglf_pkg::VAL_W'(sat);
      if (accept) begin
         if (missing) begin
            priority if (req_chan.end_of_line) begin
               push = 1'b1;
            end else if (ovf_ff) begin
               push           = 1'b1;
               push_cmd.count = lglf_pkg::CNT_W'(1);
            end else if (gap_ff >= lglf_pkg::GAP_W'(lglf_pkg::MAX_GAP)) begin
               // flush the whole gap unfilled
               push   = 1'b1;
               gap_in = '0;
               ovf_in = 1'b1;
            end else begin
               gap_in = gap_ff + lglf_pkg::GAP_W'(1);
            end
         end else begin
            push           = 1'b1;
            push_cmd.kind  = lglf_pkg::CMD_FILL;
            push_cmd.count = lglf_pkg::CNT_W'(gap_ff);
            anchor_in      = sat;
            anc_ok_in      = 1'b1;
            gap_in         = '0;
            ovf_in         = 1'b0;
         end
         if (req_chan.end_of_line) begin
            anchor_in = '0;
            anc_ok_in = 1'b0;
            gap_in    = '0;
            ovf_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff <= '0;
         anc_ok_ff <= 1'b0;
         gap_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         anchor_ff <= anchor_in;
         anc_ok_ff <= anc_ok_in;
         gap_ff    <= gap_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lglf_queue.sv @@
// Two-entry command queue between front and back end.
`default_nettype none
module lglf_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  lglf_pkg::cmd_type      push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output lglf_pkg::cmd_type      pop_cmd,
   output logic                   avail
);

   lglf_pkg::cmd_type  slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full    = (fill_ff == 2'd2);
   assign avail   = (fill_ff != 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && avail;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lglf_back.sv @@
// Back end: run commands, divide once per anchored gap, step the interpolation, drive results.
`default_nettype none
module lglf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_avail,
   input  lglf_pkg::cmd_type      q_cmd,
   output logic                   pop,
   lglf_rsp_if.source             rsp_chan
);

   localparam int VW = lglf_pkg::VAL_W;
   localparam int GW = lglf_pkg::GAP_W;
   localparam int CW = lglf_pkg::CNT_W;
   localparam int RW = lglf_pkg::RW;
   localparam int SW = lglf_pkg::DIV_STEP_W;

   lglf_pkg::back_state_type st_ff, st_in;
   lglf_pkg::cmd_type        cmd_ff, cmd_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     up_ff, up_in;
   logic [VW-1:0]            quo_ff, quo_in;     // magnitude, then quotient
   logic [GW-1:0]            drem_ff, drem_in;   // divider remainder
   logic [SW-1:0]            step_ff, step_in;
   logic [VW-1:0]            qacc_ff, qacc_in;
   logic [RW-1:0]            racc_ff, racc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [lglf_pkg::CELL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     out_ld;
   logic                     emit;
   logic [lglf_pkg::CELL_W-1:0] emit_val;
   logic                     emit_last;
   logic [GW:0]              rem_sh;
   logic                     div_ge;
   logic [GW-1:0]            rem_new;
   logic [RW-1:0]            rsum, twok;
   logic                     wrap;
   logic [RW-1:0]            racc_nx;
   logic [VW-1:0]            qacc_nx;
   logic                     fill_on;

   assign out_ld = !rsp_valid_ff || rsp_chan.ready;

   // one restoring division step
   assign rem_sh  = {drem_ff, quo_ff[VW-1]};
   assign div_ge  = rem_sh >= {1'b0, cmd_ff.count[GW-1:0]};
   assign rem_new = div_ge ? GW'(rem_sh - {1'b0, cmd_ff.count[GW-1:0]}) : rem_sh[GW-1:0];

   // quotient/remainder stepping of round(diff*j/k)
   assign rsum    = racc_ff + RW'({drem_ff, 1'b0});
   assign twok    = RW'({cmd_ff.count[GW-1:0], 1'b0});
   assign wrap    = rsum >= twok;
   assign racc_nx = wrap ? (rsum - twok) : rsum;
   assign qacc_nx = qacc_ff + quo_ff + VW'(wrap);
   assign fill_on = (cmd_ff.kind == lglf_pkg::CMD_FILL) && cmd_ff.anc_ok;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         lglf_pkg::BK_IDLE: begin
            if (q_avail) begin
               priority if (q_cmd.kind == lglf_pkg::CMD_MISS) begin
                  st_in = lglf_pkg::BK_GAP;
               end else if (q_cmd.count == CW'(0)) begin
                  st_in = lglf_pkg::BK_LAST;
               end else if (q_cmd.anc_ok) begin
                  st_in = lglf_pkg::BK_DIV;
               end else begin
                  st_in = lglf_pkg::BK_GAP;
               end
            end
         end
         lglf_pkg::BK_DIV: begin
            if (step_ff == SW'(VW - 1)) begin
               st_in = lglf_pkg::BK_GAP;
            end
         end
         lglf_pkg::BK_GAP: begin
            if (out_ld && cnt_ff == CW'(1)) begin
               st_in = (cmd_ff.kind == lglf_pkg::CMD_MISS) ? lglf_pkg::BK_IDLE
                                                          : lglf_pkg::BK_LAST;
            end
         end
         lglf_pkg::BK_LAST: begin
            if (out_ld) begin
               st_in = lglf_pkg::BK_IDLE;
            end
         end
         default: st_in = lglf_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      up_in     = up_ff;
      quo_in    = quo_ff;
      drem_in   = drem_ff;
      step_in   = step_ff;
      qacc_in   = qacc_ff;
      racc_in   = racc_ff;
      pop       = 1'b0;
      emit      = 1'b0;
      emit_val  = lglf_pkg::MISSING;
      emit_last = 1'b0;
      unique case (st_ff)
         lglf_pkg::BK_IDLE: begin
            if (q_avail) begin
               pop     = 1'b1;
               cmd_in  = q_cmd;
               cnt_in  = q_cmd.count;
               up_in   = q_cmd.value >= q_cmd.anchor;
               quo_in  = (q_cmd.value >= q_cmd.anchor) ? (q_cmd.value - q_cmd.anchor)
                                                       : (q_cmd.anchor - q_cmd.value);
               drem_in = '0;
               step_in = '0;
            end
         end
         lglf_pkg::BK_DIV: begin
            quo_in  = {quo_ff[VW-2:0], div_ge};
            drem_in = rem_new;
            step_in = step_ff + SW'(1);
            qacc_in = '0;
            racc_in = RW'(cmd_ff.count);
         end
         lglf_pkg::BK_GAP: begin
            if (out_ld) begin
               emit      = 1'b1;
               cnt_in    = cnt_ff - CW'(1);
               emit_last = (cnt_ff == CW'(1)) && (cmd_ff.kind == lglf_pkg::CMD_MISS);
               if (fill_on) begin
                  qacc_in  = qacc_nx;
                  racc_in  = racc_nx;
                  emit_val = {1'b0, up_ff ? (cmd_ff.anchor + qacc_nx)
                                          : (cmd_ff.anchor - qacc_nx)};
               end
            end
         end
         lglf_pkg::BK_LAST: begin
            if (out_ld) begin
               emit      = 1'b1;
               emit_val  = {1'b0, cmd_ff.value};
               emit_last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = emit_val;
         rsp_last_in  = emit_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.filled_value = rsp_value_ff;
   assign rsp_chan.last_of_run  = rsp_last_ff;

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cnt_ff       <= cnt_in;
      up_ff        <= up_in;
      quo_ff       <= quo_in;
      drem_ff      <= drem_in;
      step_ff      <= step_in;
      qacc_ff      <= qacc_in;
      racc_ff      <= racc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= lglf_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/lglf_checker.sv @@
// Port-level checker for the line gap fill block and its bind to the top level.
`default_nettype none
`include "line_gap_linear_fill_top_macros.svh"
module lglf_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [lglf_pkg::CELL_W-1:0]   filled_value,
   input wire logic                          last_of_run
);

   `LGLF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(filled_value) && $stable(last_of_run), "stalled result changed")
   `LGLF_ASSERT_NOW(a_neg_is_missing, rsp_valid && filled_value[lglf_pkg::CELL_W-1], filled_value == lglf_pkg::MISSING, "negative result other than missing")
   `LGLF_ASSERT_NEXT_ALWAYS(a_reset_quiet, reset, !rsp_valid, "result shown right after reset")
   `LGLF_ASSERT_NEXT_ALWAYS(a_reset_ready, reset, req_ready, "not ready right after reset")

endmodule

bind line_gap_linear_fill_top lglf_checker u_lglf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .filled_value (rsp_chan.filled_value),
   .last_of_run  (rsp_chan.last_of_run)
);
`default_nettype wire
